[hw/rtl/crtc_latch_pkg.sv]
// Package for the cartridge RTC latch registers: item types and register codes.
package crtc_latch_pkg;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] reg_req;
        logic [7:0] data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       bad_register;
    } t_out_item;

    // Operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_LATCH = 2'd3;

    // Register select codes
    localparam logic [3:0] REG_SEC     = 4'h8;
    localparam logic [3:0] REG_MIN     = 4'h9;
    localparam logic [3:0] REG_HOUR    = 4'hA;
    localparam logic [3:0] REG_DAY_LO  = 4'hB;
    localparam logic [3:0] REG_CTRL    = 4'hC;

    // Control register bits and time limits
    localparam int HALT_BIT   = 6;
    localparam int DAY8_BIT   = 0;
    localparam int CARRY_BIT  = 7;
    localparam logic [7:0] SEC_LIMIT  = 8'd60;
    localparam logic [7:0] HOUR_LIMIT = 8'd24;
    localparam logic [7:0] LATCH_ARM  = 8'h00;
    localparam logic [7:0] LATCH_FIRE = 8'h01;

    typedef enum logic [1:0] {
        LATCH_IDLE       = 2'd0,
        LATCH_ARMED      = 2'd1,
        LATCH_HELD       = 2'd2,
        LATCH_HELD_ARMED = 2'd3
    } t_latch_phase;

endpackage

[hw/rtl/cartridge_rtc_latch_regs.sv]
// Top level of the cartridge RTC: live counters, latch sequencer and snapshot registers.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) carries one item per
//   access: a one-second tick, a register read, a register write or a
//   latch-area write. Output channel (o_out_valid / i_out_stall / o_out)
//   returns exactly one item for every input item, in order.
//   An accepted item passes the input register, then the result register;
//   o_out_valid rises when the item reaches the result register.
//   Throughput: one item per cycle while the receiver does not stall; the
//   whole update of counters, latch phase and snapshot is one register-to-
//   register pass, with the seconds-to-days carry chain as the longest path.
//   When the receiver stalls, the result register holds its item and the
//   input register still takes one more item; after that o_in_stall rises
//   until the result is taken. State only changes when an item moves from
//   the input register to the result register, so stalls never disturb it.
//   Reset (i_rst_n low, synchronous) clears all counters, runs the clock,
//   drops the latch phase to idle, zeroes the snapshot and empties both
//   registers. Reads return 0 until the first completed latch sequence.
module cartridge_rtc_latch_regs (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  crtc_latch_pkg::t_in_item i_in,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output crtc_latch_pkg::t_out_item o_out
);
    import crtc_latch_pkg::*;

    // Input register
    logic     r_in_valid;
    t_in_item r_in;

    // Result register
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    // Live clock
    logic [5:0] r_sec,  n_sec;
    logic [5:0] r_min,  n_min;
    logic [4:0] r_hour, n_hour;
    logic [8:0] r_days, n_days;
    logic       r_ovf,  n_ovf;
    logic       r_halted, n_halted;

    // Latch sequencer and snapshot
    t_latch_phase r_phase, n_phase;
    logic         snap_en;
    logic [7:0]   r_snap [5];
    logic [7:0]   ctrl_byte;

    logic advance;
    logic accept;
    logic reg_ok;

    // Item moves forward when the result slot is free or being emptied
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign reg_ok    = r_in.reg_req inside {[REG_SEC:REG_CTRL]};
    assign ctrl_byte = {r_ovf, r_halted, 5'b0, r_days[8]};

    // Latch phase: next state
    always_comb begin
        n_phase = r_phase;
        if (r_in.op == OP_LATCH) begin
            case (r_phase)
                LATCH_IDLE: begin
                    if (r_in.data == LATCH_ARM) n_phase = LATCH_ARMED;
                end
                LATCH_ARMED: begin
                    n_phase = (r_in.data == LATCH_FIRE) ? LATCH_HELD : LATCH_IDLE;
                end
                LATCH_HELD: begin
                    if (r_in.data == LATCH_ARM) n_phase = LATCH_HELD_ARMED;
                end
                LATCH_HELD_ARMED: begin
                    n_phase = LATCH_HELD;
                end
                default: begin
                    n_phase = LATCH_IDLE;
                end
            endcase
        end
    end

    // Latch phase: snapshot strobe
    always_comb begin
        snap_en = 1'b0;
        if (r_in.op == OP_LATCH && r_in.data == LATCH_FIRE) begin
            case (r_phase)
                LATCH_ARMED, LATCH_HELD_ARMED: snap_en = 1'b1;
                default:                       snap_en = 1'b0;
            endcase
        end
    end

    // Live clock update and result
    always_comb begin
        n_sec    = r_sec;
        n_min    = r_min;
        n_hour   = r_hour;
        n_days   = r_days;
        n_ovf    = r_ovf;
        n_halted = r_halted;
        n_out    = '0;

        case (r_in.op)
            OP_TICK: begin
                if (!r_halted) begin
                    // carry ripples only when the lower unit wraps
                    if ({2'b0, r_sec} < SEC_LIMIT - 8'd1) begin
                        n_sec = r_sec + 6'd1;
                    end else begin
                        n_sec = '0;
                        if ({2'b0, r_min} < SEC_LIMIT - 8'd1) begin
                            n_min = r_min + 6'd1;
                        end else begin
                            n_min = '0;
                            if ({3'b0, r_hour} < HOUR_LIMIT - 8'd1) begin
                                n_hour = r_hour + 5'd1;
                            end else begin
                                n_hour = '0;
                                if (&r_days) begin
                                    n_days = '0;
                                    n_ovf  = 1'b1;
                                end else begin
                                    n_days = r_days + 9'd1;
                                end
                            end
                        end
                    end
                end
            end
            OP_READ: begin
                if (!reg_ok) begin
                    n_out.bad_register = 1'b1;
                end else if (r_phase == LATCH_HELD || r_phase == LATCH_HELD_ARMED) begin
                    case (r_in.reg_req)
                        REG_SEC:    n_out.read_data = r_snap[0];
                        REG_MIN:    n_out.read_data = r_snap[1];
                        REG_HOUR:   n_out.read_data = r_snap[2];
                        REG_DAY_LO: n_out.read_data = r_snap[3];
                        default:    n_out.read_data = r_snap[4];
                    endcase
                end
            end
            OP_WRITE: begin
                if (!reg_ok) begin
                    n_out.bad_register = 1'b1;
                end else if (r_in.reg_req == REG_CTRL) begin
                    if (!r_halted) begin
                        n_halted = r_in.data[HALT_BIT];
                    end else if (r_in.data[HALT_BIT]) begin
                        n_days[8] = r_in.data[DAY8_BIT];
                        n_ovf     = r_in.data[CARRY_BIT];
                    end else begin
                        n_halted = 1'b0;
                    end
                end else if (r_halted) begin
                    // time registers only take writes while halted
                    case (r_in.reg_req)
                        REG_SEC:  n_sec  = (r_in.data < SEC_LIMIT)  ? r_in.data[5:0] : '0;
                        REG_MIN:  n_min  = (r_in.data < SEC_LIMIT)  ? r_in.data[5:0] : '0;
                        REG_HOUR: n_hour = (r_in.data < HOUR_LIMIT) ? r_in.data[4:0] : '0;
                        default:  n_days = {r_days[8], r_in.data};
                    endcase
                end
            end
            default: begin
                // latch-area write: handled by the sequencer
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_sec       <= '0;
            r_min       <= '0;
            r_hour      <= '0;
            r_days      <= '0;
            r_ovf       <= 1'b0;
            r_halted    <= 1'b0;
            r_phase     <= LATCH_IDLE;
            for (int i = 0; i < 5; i++) r_snap[i] <= '0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (advance) begin
                r_sec    <= n_sec;
                r_min    <= n_min;
                r_hour   <= n_hour;
                r_days   <= n_days;
                r_ovf    <= n_ovf;
                r_halted <= n_halted;
                r_phase  <= n_phase;
                if (snap_en) begin
                    r_snap[0] <= {2'b0, r_sec};
                    r_snap[1] <= {2'b0, r_min};
                    r_snap[2] <= {3'b0, r_hour};
                    r_snap[3] <= r_days[7:0];
                    r_snap[4] <= ctrl_byte;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) r_in <= i_in;
        if (advance) r_out <= n_out;
    end

    // Assertions
    a_sec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {2'b0, r_sec} < SEC_LIMIT && {2'b0, r_min} < SEC_LIMIT)
        else $error("live seconds or minutes out of range");

    a_hour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {3'b0, r_hour} < HOUR_LIMIT)
        else $error("live hours out of range");

    a_halt_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_halted && r_in.op == OP_TICK |=>
            $stable(r_sec) && $stable(r_min) && $stable(r_hour) && $stable(r_days))
        else $error("tick changed the clock while halted");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.bad_register |-> r_out.read_data == 8'd0)
        else $error("bad register result carries data");

endmodule
